FILE: rtl/aobn_pkg.sv
// ----------------------------------------------------------------------------
// aobn_pkg
// Shared types and constants of the area-ordered box suppression unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aobn_pkg;

	// Depth of the small queues between the parts of the unit
	localparam int FIFO_DEPTH = 4;

	// Reset value of the IoU threshold, about 0.3 in Q0.16
	localparam logic [15:0] IOU_THR_RESET = 16'd19661;

	// Cap on results per batch, and the number of results that may be sent early
	localparam int RESULT_CAP = 32;
	localparam logic [5:0] EARLY_CAP = 6'(RESULT_CAP - 1);

	// Classified box travelling from the front part to the back part
	typedef struct packed {
		logic [15:0] left_x;
		logic [15:0] top_y;
		logic [15:0] right_x;
		logic [15:0] bottom_y;
		logic [31:0] area;
		logic        store;
		logic        last;
		logic        ovf;
	} mid_t;

	// One result item
	typedef struct packed {
		logic [4:0] kept_index;
		logic       last_kept;
		logic       overflow;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/area_ordered_box_nms_unit.sv
// ----------------------------------------------------------------------------
// area_ordered_box_nms_unit
// Greedy IoU box suppression with boxes visited in descending area order.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          left_x top_y right_x bottom_y batch_end
//  result    pop / empty          kept_index last_kept overflow
//  config    cfg_valid/cfg_ready  cfg_data (IoU threshold, Q0.16)
//
//  A box is taken whenever push is high and the input queue has room. The
//  closing box starts the batch pass in the back part: ranking and then
//  suppression, both paced by the single read port of each batch memory.
//  No clearing pass after reset.
//  A full result queue stalls suppression; a busy back part fills the input
//  queue and raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module area_ordered_box_nms_unit #(
	parameter int MAX_BOXES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] left_x,
	input  wire logic [15:0] top_y,
	input  wire logic [15:0] right_x,
	input  wire logic [15:0] bottom_y,
	input  wire logic        batch_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [4:0]       kept_index,
	output logic             last_kept,
	output logic             overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import aobn_pkg::*;

	logic [15:0] thr_q;
	mid_t        entry;
	mid_t        mid_head;
	logic        mid_empty;
	logic        mid_pop;
	logic        res_push;
	res_t        res_in;
	res_t        res_head;
	logic        res_full;

	// Hold the threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IOU_THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	aobn_front #(.MAX_BOXES(MAX_BOXES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !full),
		.left_x    (left_x),
		.top_y     (top_y),
		.right_x   (right_x),
		.bottom_y  (bottom_y),
		.batch_end (batch_end),
		.entry     (entry)
	);

	aobn_fifo #(.W($bits(mid_t))) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_head),
		.empty  (mid_empty)
	);

	aobn_back #(.MAX_BOXES(MAX_BOXES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (thr_q),
		.mid_empty (mid_empty),
		.mid_data  (mid_head),
		.mid_pop   (mid_pop),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_data  (res_in)
	);

	aobn_fifo #(.W($bits(res_t))) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty)
	);

	// Present the oldest result transfer
	assign kept_index = res_head.kept_index;
	assign last_kept  = res_head.last_kept;
	assign overflow   = res_head.overflow;

endmodule

`default_nettype wire

FILE: rtl/aobn_fifo.sv
// ----------------------------------------------------------------------------
// aobn_fifo
// Small show-ahead queue; head entry is visible while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module aobn_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);
	import aobn_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/aobn_front.sv
// ----------------------------------------------------------------------------
// aobn_front
// Accepts boxes, works out their area and marks those beyond capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module aobn_front #(
	parameter int MAX_BOXES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [15:0] left_x,
	input  wire logic [15:0] top_y,
	input  wire logic [15:0] right_x,
	input  wire logic [15:0] bottom_y,
	input  wire logic        batch_end,
	output aobn_pkg::mid_t   entry
);
	import aobn_pkg::*;

	localparam int CW = $clog2(MAX_BOXES + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          store;
	logic          wf_ok;
	logic [15:0]   dx;
	logic [15:0]   dy;

	// Classify: well-formed box, room left in the store
	assign wf_ok = (right_x > left_x) && (bottom_y > top_y);
	assign dx    = right_x - left_x;
	assign dy    = bottom_y - top_y;
	assign store = (count_q < CW'(MAX_BOXES));

	always_comb begin
		entry.left_x   = left_x;
		entry.top_y    = top_y;
		entry.right_x  = right_x;
		entry.bottom_y = bottom_y;
		entry.area     = wf_ok ? (32'(dx) * 32'(dy)) : '0;
		entry.store    = store;
		entry.last     = batch_end;
		entry.ovf      = ovf_q || !store;
	end

	// Count boxes of the open batch, drop count at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (batch_end) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (store) begin
				count_q <= CW'(count_q + 1'b1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/aobn_back.sv
// ----------------------------------------------------------------------------
// aobn_back
// Stores a batch, ranks boxes by area and runs greedy IoU suppression.
// ----------------------------------------------------------------------------
`default_nettype none

module aobn_back #(
	parameter int MAX_BOXES = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    threshold,
	input  wire logic           mid_empty,
	input  wire aobn_pkg::mid_t mid_data,
	output logic                mid_pop,
	input  wire logic           out_full,
	output logic                out_push,
	output aobn_pkg::res_t      out_data
);
	import aobn_pkg::*;

	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_RP, S_RPW, S_RQ, S_RQC, S_RW,
		S_NP, S_NPI, S_NPB, S_NQ, S_NQJ, S_NQI, S_NQU, S_NQT, S_FIN
	} state_t;

	state_t          state_q;
	logic [63:0]     box_mem [MAX_BOXES];
	logic [31:0]     area_mem [MAX_BOXES];
	logic [IW-1:0]   order_mem [MAX_BOXES];
	logic [63:0]     box_rd_q;
	logic [31:0]     area_rd_q;
	logic [IW-1:0]   order_rd_q;
	logic [IW-1:0]   box_ra;
	logic [IW-1:0]   area_ra;
	logic [IW-1:0]   order_ra;

	logic [CW-1:0]   n_q;
	logic [CW-1:0]   p_q;
	logic [CW-1:0]   q_q;
	logic [IW-1:0]   rank_q;
	logic [31:0]     ap_q;
	logic [MAX_BOXES-1:0] supp_q;
	logic            ovf_q;
	logic [IW-1:0]   j_q;
	logic [63:0]     bi_q;
	logic [31:0]     ai_q;
	logic [31:0]     aj_q;
	logic [31:0]     inter_q;
	logic            iv_q;
	logic [48:0]     prod_q;
	logic            ok_q;
	logic            pend_v_q;
	logic [IW-1:0]   pend_q;
	logic [5:0]      pushed_q;

	logic            ld_wr;
	logic            need_push;
	logic [15:0]     il;
	logic [15:0]     it;
	logic [15:0]     ir;
	logic [15:0]     ib;
	logic [15:0]     iw;
	logic [15:0]     ih;
	logic [32:0]     sum;
	logic [32:0]     uni;
	logic [CW-1:0]   p_nx;
	logic [CW-1:0]   q_nx;

	assign ld_wr     = (state_q == S_LOAD) && !mid_empty && mid_data.store;
	assign mid_pop   = (state_q == S_LOAD);
	assign need_push = pend_v_q && (pushed_q < EARLY_CAP);
	assign p_nx      = CW'(p_q + 1'b1);
	assign q_nx      = CW'(q_q + 1'b1);

	// Choose read addresses per step
	always_comb begin
		area_ra  = p_q[IW-1:0];
		box_ra   = order_rd_q;
		order_ra = p_q[IW-1:0];
		case (state_q)
			S_RQ:    area_ra = q_q[IW-1:0];
			S_NPI:   area_ra = order_rd_q;
			S_NQJ:   area_ra = order_rd_q;
			S_NQ:    order_ra = q_q[IW-1:0];
			default: area_ra = p_q[IW-1:0];
		endcase
	end

	// Overlap of the held box with the box just read
	assign il  = (bi_q[15:0]  > box_rd_q[15:0])  ? bi_q[15:0]  : box_rd_q[15:0];
	assign it  = (bi_q[31:16] > box_rd_q[31:16]) ? bi_q[31:16] : box_rd_q[31:16];
	assign ir  = (bi_q[47:32] < box_rd_q[47:32]) ? bi_q[47:32] : box_rd_q[47:32];
	assign ib  = (bi_q[63:48] < box_rd_q[63:48]) ? bi_q[63:48] : box_rd_q[63:48];
	assign iw  = ir - il;
	assign ih  = ib - it;
	assign sum = 33'(ai_q) + 33'(aj_q);
	assign uni = sum - 33'(inter_q);

	// Memories: write and registered read
	always_ff @(posedge clk) begin
		if (ld_wr) begin
			box_mem[n_q[IW-1:0]]  <= {mid_data.bottom_y, mid_data.right_x,
				mid_data.top_y, mid_data.left_x};
			area_mem[n_q[IW-1:0]] <= mid_data.area;
		end
		if (state_q == S_RW) begin
			order_mem[rank_q] <= p_q[IW-1:0];
		end
		box_rd_q   <= box_mem[box_ra];
		area_rd_q  <= area_mem[area_ra];
		order_rd_q <= order_mem[order_ra];
	end

	// Sequencer: load, rank, suppress, flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			n_q      <= '0;
			p_q      <= '0;
			q_q      <= '0;
			rank_q   <= '0;
			supp_q   <= '0;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			pushed_q <= '0;
			out_push <= 1'b0;
			out_data <= '0;
		end else begin
			out_push <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (!mid_empty) begin
						if (mid_data.store) begin
							n_q <= CW'(n_q + 1'b1);
						end
						if (mid_data.last) begin
							ovf_q  <= mid_data.ovf;
							p_q    <= '0;
							rank_q <= '0;
							if (mid_data.store || n_q != '0) begin
								state_q <= S_RP;
							end else begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_RP: state_q <= S_RPW;
				S_RPW: begin
					ap_q    <= area_rd_q;
					q_q     <= '0;
					state_q <= S_RQ;
				end
				S_RQ: state_q <= S_RQC;
				S_RQC: begin
					// Count boxes that rank ahead of box p
					if (area_rd_q > ap_q || (area_rd_q == ap_q && q_q < p_q)) begin
						rank_q <= IW'(rank_q + 1'b1);
					end
					q_q     <= q_nx;
					state_q <= (q_nx == n_q) ? S_RW : S_RQ;
				end
				S_RW: begin
					rank_q <= '0;
					if (p_nx == n_q) begin
						p_q     <= '0;
						state_q <= S_NP;
					end else begin
						p_q     <= p_nx;
						state_q <= S_RP;
					end
				end
				S_NP: state_q <= S_NPI;
				S_NPI: begin
					if (supp_q[order_rd_q]) begin
						p_q     <= p_nx;
						state_q <= (p_nx == n_q) ? S_FIN : S_NP;
					end else if (!(need_push && out_full)) begin
						// Keep this box: send the one held back before it and hold this one; past the early cap nothing is sent or held
						if (need_push) begin
							out_push <= 1'b1;
							out_data <= '{kept_index: 5'(pend_q), last_kept: 1'b0,
								overflow: ovf_q};
							pushed_q <= 6'(pushed_q + 1'b1);
							pend_q   <= order_rd_q;
						end else if (!pend_v_q) begin
							pend_v_q <= 1'b1;
							pend_q   <= order_rd_q;
						end
						state_q <= S_NPB;
					end
				end
				S_NPB: begin
					bi_q <= box_rd_q;
					ai_q <= area_rd_q;
					q_q  <= p_nx;
					if (p_nx == n_q) begin
						p_q     <= p_nx;
						state_q <= S_FIN;
					end else begin
						state_q <= S_NQ;
					end
				end
				S_NQ: state_q <= S_NQJ;
				S_NQJ: begin
					j_q <= order_rd_q;
					if (supp_q[order_rd_q]) begin
						q_q <= q_nx;
						if (q_nx == n_q) begin
							p_q     <= p_nx;
							state_q <= (p_nx == n_q) ? S_FIN : S_NP;
						end else begin
							state_q <= S_NQ;
						end
					end else begin
						state_q <= S_NQI;
					end
				end
				S_NQI: begin
					iv_q    <= (il < ir) && (it < ib);
					inter_q <= 32'(iw) * 32'(ih);
					aj_q    <= area_rd_q;
					state_q <= S_NQU;
				end
				S_NQU: begin
					ok_q    <= iv_q && (sum > 33'(inter_q));
					prod_q  <= 49'(threshold) * 49'(uni);
					state_q <= S_NQT;
				end
				S_NQT: begin
					// Drop box j when IoU is above threshold
					if (ok_q && ({inter_q, 16'd0} > 48'(prod_q)) && (prod_q[48] == 1'b0)) begin
						supp_q[j_q] <= 1'b1;
					end
					q_q <= q_nx;
					if (q_nx == n_q) begin
						p_q     <= p_nx;
						state_q <= (p_nx == n_q) ? S_FIN : S_NP;
					end else begin
						state_q <= S_NQ;
					end
				end
				S_FIN: begin
					if (!(pend_v_q && out_full)) begin
						if (pend_v_q) begin
							out_push <= 1'b1;
							out_data <= '{kept_index: 5'(pend_q), last_kept: 1'b1,
								overflow: ovf_q};
						end
						pend_v_q <= 1'b0;
						pushed_q <= '0;
						supp_q   <= '0;
						n_q      <= '0;
						state_q  <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

`default_nettype wire
